@@ rtl/plst_pkg.sv @@
// ----------------------------------------------------------------------------
// plst_pkg
// Shared widths, mode and status codes, and the controller/datapath
// command and status types of the positional list store.
// ----------------------------------------------------------------------------
package plst_pkg;

    localparam int MODE_W = 3;
    localparam int POS_W  = 7;
    localparam int VAL_W  = 32;
    localparam int STAT_W = 2;

    // Operation modes on i_mode
    localparam logic [MODE_W-1:0] MODE_INSERT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_APPEND = 3'd1;
    localparam logic [MODE_W-1:0] MODE_DELETE = 3'd2;
    localparam logic [MODE_W-1:0] MODE_READ   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_FIND   = 3'd4;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_BADPOS   = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd2;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

    // One datapath operation per cycle
    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,    // capture the request
        DP_INIT,    // set the walk pointer for the mode
        DP_UP,      // shift one entry up (insert)
        DP_PUT,     // write the new value, count + 1
        DP_DOWN,    // shift one entry down (delete)
        DP_DEC,     // count - 1
        DP_READ,    // read one entry
        DP_SCAN,    // read and compare one entry (find)
        DP_EMIT     // load the result registers
    } t_dp_op;

    typedef struct packed {
        t_dp_op              op;
        logic [STAT_W-1:0]   status;
    } t_dp_cmd;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              ins_bad;
        logic              full;
        logic              pos_bad;
        logic              up_more;
        logic              down_more;
        logic              hit;
        logic              scan_end;
    } t_dp_stat;

endpackage

@@ rtl/plst_dp.sv @@
// ----------------------------------------------------------------------------
// plst_dp
// Datapath: entry store, count, walk pointer, one-deep write-behind for
// shifts, compare stage for find, and the result registers.
// ----------------------------------------------------------------------------
module plst_dp #(
    parameter int LIST_DEPTH = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic [plst_pkg::MODE_W-1:0]          i_mode,
    input  logic [plst_pkg::POS_W-1:0]           i_position,
    input  logic signed [plst_pkg::VAL_W-1:0]    i_value,
    input  plst_pkg::t_dp_cmd                    i_cmd,
    output plst_pkg::t_dp_stat                   o_stat,
    output logic [plst_pkg::STAT_W-1:0]          o_status,
    output logic signed [plst_pkg::VAL_W-1:0]    o_read_value,
    output logic [plst_pkg::POS_W-1:0]           o_found_position,
    output logic [plst_pkg::POS_W-1:0]           o_item_total
);

    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam int AW = $clog2(LIST_DEPTH);
    localparam int XW = ((CW > plst_pkg::POS_W) ? CW : plst_pkg::POS_W) + 1;

    logic [plst_pkg::VAL_W-1:0]  r_mem [LIST_DEPTH];
    logic [plst_pkg::VAL_W-1:0]  r_rd_data;

    logic [plst_pkg::MODE_W-1:0] r_mode;
    logic [plst_pkg::POS_W-1:0]  r_pos;
    logic [plst_pkg::VAL_W-1:0]  r_val;
    logic [CW-1:0]               r_cnt;
    logic [CW-1:0]               r_ptr;
    logic                        r_pend;
    logic [AW-1:0]               r_pend_addr;
    logic                        r_cmp_valid;
    logic [CW-1:0]               r_cmp_pos;
    logic [CW-1:0]               r_found;

    logic [XW-1:0] pos_x, cnt_x, ptr_x, eff_x, found_x;
    logic [XW-1:0] pos_m1, ptr_m1, eff_m1;
    logic          is_append, ins_bad, full, pos_bad, up_more, down_more, hit;
    logic          we, re;
    logic [AW-1:0] wa, ra;
    logic [plst_pkg::VAL_W-1:0] wd;
    plst_pkg::t_dp_op op;

    assign op = i_cmd.op;

    assign pos_x   = {{(XW - plst_pkg::POS_W){1'b0}}, r_pos};
    assign cnt_x   = {{(XW - CW){1'b0}}, r_cnt};
    assign ptr_x   = {{(XW - CW){1'b0}}, r_ptr};
    assign found_x = {{(XW - CW){1'b0}}, r_found};

    assign is_append = (r_mode == plst_pkg::MODE_APPEND);
    assign eff_x     = is_append ? (cnt_x + XW'(1)) : pos_x;
    assign pos_m1    = pos_x - XW'(1);
    assign ptr_m1    = ptr_x - XW'(1);
    assign eff_m1    = eff_x - XW'(1);

    assign ins_bad   = (eff_x == '0) || (eff_x > (cnt_x + XW'(1)));
    assign full      = (cnt_x == XW'(LIST_DEPTH));
    assign pos_bad   = (pos_x == '0) || (pos_x > cnt_x);
    assign up_more   = (ptr_x >= eff_x);
    assign down_more = (ptr_x < cnt_x);
    assign hit       = r_cmp_valid && (r_rd_data == r_val);

    always_comb begin
        o_stat           = '0;
        o_stat.mode      = r_mode;
        o_stat.ins_bad   = ins_bad;
        o_stat.full      = full;
        o_stat.pos_bad   = pos_bad;
        o_stat.up_more   = up_more;
        o_stat.down_more = down_more;
        o_stat.hit       = hit;
        o_stat.scan_end  = !down_more && !r_cmp_valid;
    end

    // Store port: a pending shift write wins; PUT never overlaps one.
    assign we = r_pend || (op == plst_pkg::DP_PUT);
    assign wa = r_pend ? r_pend_addr : eff_m1[AW-1:0];
    assign wd = r_pend ? r_rd_data : r_val;

    always_comb begin
        re = 1'b0;
        ra = ptr_x[AW-1:0];
        case (op)
            plst_pkg::DP_UP: begin
                re = up_more;
                ra = ptr_m1[AW-1:0];
            end
            plst_pkg::DP_DOWN: begin
                re = down_more;
            end
            plst_pkg::DP_READ: begin
                re = 1'b1;
                ra = pos_m1[AW-1:0];
            end
            plst_pkg::DP_SCAN: begin
                re = down_more;
            end
            default: begin
                re = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wa] <= wd;
        end
        if (re) begin
            r_rd_data <= r_mem[ra];
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_pend      <= 1'b0;
            r_cmp_valid <= 1'b0;
        end else begin
            r_pend      <= ((op == plst_pkg::DP_UP) && up_more) ||
                           ((op == plst_pkg::DP_DOWN) && down_more);
            r_cmp_valid <= (op == plst_pkg::DP_SCAN) && down_more;
            if (op == plst_pkg::DP_PUT) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (op == plst_pkg::DP_DEC) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    // Payload and pointer
    always_ff @(posedge i_clk) begin
        r_pend_addr <= (op == plst_pkg::DP_UP) ? ptr_x[AW-1:0] : ptr_m1[AW-1:0];
        r_cmp_pos   <= r_ptr + CW'(1);
        case (op)
            plst_pkg::DP_LOAD: begin
                r_mode <= i_mode;
                r_pos  <= i_position;
                r_val  <= i_value;
            end
            plst_pkg::DP_INIT: begin
                if (r_mode inside {plst_pkg::MODE_INSERT, plst_pkg::MODE_APPEND}) begin
                    r_ptr <= r_cnt;
                end else if (r_mode == plst_pkg::MODE_DELETE) begin
                    r_ptr <= pos_x[CW-1:0];
                end else begin
                    r_ptr <= '0;
                end
            end
            plst_pkg::DP_UP: begin
                if (up_more) begin
                    r_ptr <= r_ptr - CW'(1);
                end
            end
            plst_pkg::DP_DOWN: begin
                if (down_more) begin
                    r_ptr <= r_ptr + CW'(1);
                end
            end
            plst_pkg::DP_SCAN: begin
                if (down_more) begin
                    r_ptr <= r_ptr + CW'(1);
                end
                if (hit) begin
                    r_found <= r_cmp_pos;
                end
            end
            plst_pkg::DP_EMIT: begin
                o_status     <= i_cmd.status;
                o_read_value <= ((i_cmd.status == plst_pkg::ST_OK) &&
                                 (r_mode == plst_pkg::MODE_READ)) ? r_rd_data : '0;
                o_found_position <= ((i_cmd.status == plst_pkg::ST_OK) &&
                                     (r_mode == plst_pkg::MODE_FIND)) ?
                                    found_x[plst_pkg::POS_W-1:0] : '0;
                o_item_total <= cnt_x[plst_pkg::POS_W-1:0];
            end
            default: begin
                r_ptr <= r_ptr;
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cnt_x <= XW'(LIST_DEPTH))
        else $error("entry count above depth");

    a_one_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_pend && (op == plst_pkg::DP_PUT)))
        else $error("shift write collides with value write");

    a_cnt_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((op != plst_pkg::DP_PUT) && (op != plst_pkg::DP_DEC)) |=> $stable(r_cnt))
        else $error("count moved without put or dec");
`endif

endmodule

@@ rtl/plst_ctrl.sv @@
// ----------------------------------------------------------------------------
// plst_ctrl
// Controller: sequences each request through check, walk and result
// phases, issuing one datapath operation per cycle.
// ----------------------------------------------------------------------------
module plst_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    output logic                o_valid,
    input  plst_pkg::t_dp_stat  i_stat,
    output plst_pkg::t_dp_cmd   o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_EVAL, S_UP, S_PUT, S_DOWN, S_DEC, S_READ, S_SCAN, S_DONE
    } t_state;

    t_state                         r_state;
    logic [plst_pkg::STAT_W-1:0]    r_st;
    logic                           r_valid;

    assign busy    = (r_state != S_IDLE);
    assign o_valid = r_valid;

    always_comb begin
        o_cmd        = '0;
        o_cmd.op     = plst_pkg::DP_NOP;
        o_cmd.status = r_st;
        case (r_state)
            S_IDLE:  o_cmd.op = start ? plst_pkg::DP_LOAD : plst_pkg::DP_NOP;
            S_EVAL:  o_cmd.op = plst_pkg::DP_INIT;
            S_UP:    o_cmd.op = plst_pkg::DP_UP;
            S_PUT:   o_cmd.op = plst_pkg::DP_PUT;
            S_DOWN:  o_cmd.op = plst_pkg::DP_DOWN;
            S_DEC:   o_cmd.op = plst_pkg::DP_DEC;
            S_READ:  o_cmd.op = plst_pkg::DP_READ;
            S_SCAN:  o_cmd.op = plst_pkg::DP_SCAN;
            S_DONE:  o_cmd.op = plst_pkg::DP_EMIT;
            default: o_cmd.op = plst_pkg::DP_NOP;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_st    <= plst_pkg::ST_OK;
            r_valid <= 1'b0;
        end else begin
            r_valid <= (r_state == S_DONE);
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    case (i_stat.mode)
                        plst_pkg::MODE_INSERT, plst_pkg::MODE_APPEND: begin
                            if (i_stat.ins_bad) begin
                                r_st    <= plst_pkg::ST_BADPOS;
                                r_state <= S_DONE;
                            end else if (i_stat.full) begin
                                r_st    <= plst_pkg::ST_FULL;
                                r_state <= S_DONE;
                            end else begin
                                r_st    <= plst_pkg::ST_OK;
                                r_state <= S_UP;
                            end
                        end
                        plst_pkg::MODE_DELETE: begin
                            if (i_stat.pos_bad) begin
                                r_st    <= plst_pkg::ST_BADPOS;
                                r_state <= S_DONE;
                            end else begin
                                r_st    <= plst_pkg::ST_OK;
                                r_state <= S_DOWN;
                            end
                        end
                        plst_pkg::MODE_READ: begin
                            if (i_stat.pos_bad) begin
                                r_st    <= plst_pkg::ST_BADPOS;
                                r_state <= S_DONE;
                            end else begin
                                r_st    <= plst_pkg::ST_OK;
                                r_state <= S_READ;
                            end
                        end
                        plst_pkg::MODE_FIND: begin
                            r_st    <= plst_pkg::ST_OK;
                            r_state <= S_SCAN;
                        end
                        default: begin
                            r_st    <= plst_pkg::ST_OK;
                            r_state <= S_DONE;
                        end
                    endcase
                end
                S_UP: begin
                    if (!i_stat.up_more) begin
                        r_state <= S_PUT;
                    end
                end
                S_PUT: begin
                    r_state <= S_DONE;
                end
                S_DOWN: begin
                    if (!i_stat.down_more) begin
                        r_state <= S_DEC;
                    end
                end
                S_DEC: begin
                    r_state <= S_DONE;
                end
                S_READ: begin
                    r_state <= S_DONE;
                end
                S_SCAN: begin
                    if (i_stat.hit) begin
                        r_st    <= plst_pkg::ST_OK;
                        r_state <= S_DONE;
                    end else if (i_stat.scan_end) begin
                        r_st    <= plst_pkg::ST_NOTFOUND;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_state == S_IDLE))
        else $error("result strobe while a request is in flight");

    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |=> !r_valid)
        else $error("result strobe longer than one cycle");

    a_accept_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (r_state == S_EVAL))
        else $error("accepted request not evaluated");
`endif

endmodule

@@ rtl/positional_list_store.sv @@
// ----------------------------------------------------------------------------
// positional_list_store
// Ordered list of signed 32-bit values in a fixed store with a count:
// insert, append, delete, read at a 1-based position, and find a value.
// ----------------------------------------------------------------------------
// Usage
//   Request: drive i_mode, i_position and i_value and raise start; the
//   transfer happens at the rising edge where start is high and busy is low.
//   busy stays high until the result is presented.
//   Result: o_status, o_read_value, o_found_position and o_item_total are
//   valid for exactly one cycle, marked by o_valid. The receiver cannot
//   stall; it must take the result in that cycle.
//   Each request is checked first; bad position, full and unused modes go
//   straight to the result. Read fetches one entry; insert / append shift
//   the entries from the given position to the end up and then write the
//   value; delete shifts the entries above the position down and then
//   lowers the count; find compares from position 1 until the first match
//   or the end of the list. The store has one read and one write port and
//   moves or compares one entry per cycle. busy falls in the strobe cycle,
//   so the next request can be taken then.
//   Reset (synchronous, active low) empties the list at once; the store
//   contents need no clearing, since only entries below the count are read.
// ----------------------------------------------------------------------------
module positional_list_store #(
    parameter int LIST_DEPTH = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [plst_pkg::MODE_W-1:0]          i_mode,
    input  logic [plst_pkg::POS_W-1:0]           i_position,
    input  logic signed [plst_pkg::VAL_W-1:0]    i_value,
    output logic                                 o_valid,
    output logic [plst_pkg::STAT_W-1:0]          o_status,
    output logic signed [plst_pkg::VAL_W-1:0]    o_read_value,
    output logic [plst_pkg::POS_W-1:0]           o_found_position,
    output logic [plst_pkg::POS_W-1:0]           o_item_total
);

    // Controller to datapath: one operation per cycle plus the final status.
    plst_pkg::t_dp_cmd  dp_cmd;
    // Datapath to controller: range checks and walk/scan progress.
    plst_pkg::t_dp_stat dp_stat;

    plst_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_valid (o_valid),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd)
    );

    // Result registers live in the datapath and load in the cycle before
    // the strobe, so they line up with o_valid.
    plst_dp #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_mode           (i_mode),
        .i_position       (i_position),
        .i_value          (i_value),
        .i_cmd            (dp_cmd),
        .o_stat           (dp_stat),
        .o_status         (o_status),
        .o_read_value     (o_read_value),
        .o_found_position (o_found_position),
        .o_item_total     (o_item_total)
    );

endmodule
